/* hdl/gcsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared types, codes and constant tables of the GIF container stream parser.
// ----------------------------------------------------------------------------
package gcsp_pkg;

  // Event codes on the result word
  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_SCREEN    = 4'd1,
    EV_GCTRL     = 4'd2,
    EV_LOOP      = 4'd3,
    EV_IMGDESC   = 4'd4,
    EV_GLOBAL    = 4'd5,
    EV_LOCAL     = 4'd6,
    EV_CODE_BYTE = 4'd7,
    EV_DATA_END  = 4'd8,
    EV_MIN_CODE  = 4'd9,
    EV_TRAILER   = 4'd10,
    EV_ERROR     = 4'd11
  } event_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_HEADER     = 3'd1,
    ERR_BLOCK_ID   = 3'd2,
    ERR_EXT_SIZE   = 3'd3,
    ERR_LOOP_BLOCK = 3'd4,
    ERR_TERMINATOR = 3'd5,
    ERR_DATA_LEN   = 3'd6
  } error_e;

  // Block introducers, labels and fixed sizes
  localparam logic [7:0] ExtIntro    = 8'h21;
  localparam logic [7:0] ImgSep      = 8'h2C;
  localparam logic [7:0] Trailer     = 8'h3B;
  localparam logic [7:0] GctrlLabel  = 8'hF9;
  localparam logic [7:0] AppLabel    = 8'hFF;
  localparam logic [7:0] GctrlSize   = 8'h04;
  localparam logic [7:0] AppSize     = 8'h0B;
  localparam logic [7:0] LoopSubSize = 8'h03;
  localparam logic [7:0] LoopSubId   = 8'h01;
  localparam logic [7:0] MaxBlkReset = 8'hFF;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_t;

  // Result word
  typedef struct packed {
    logic [3:0]  event_res;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] third_value;
    logic [15:0] fourth_value;
    logic [23:0] palette_rgb;
    logic        transparency_on;
    logic [2:0]  disposal_method;
    logic        interlaced;
    logic        animated;
    logic [2:0]  error_code;
  } out_t;

  // Signature "GIF89a"
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h46;
      3'd3:    c = 8'h38;
      3'd4:    c = 8'h39;
      3'd5:    c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Application identifier "NETSCAPE2.0"
  function automatic logic [7:0] app_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4E;
      4'd1:    c = 8'h45;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h53;
      4'd4:    c = 8'h43;
      4'd5:    c = 8'h41;
      4'd6:    c = 8'h50;
      4'd7:    c = 8'h45;
      4'd8:    c = 8'h32;
      4'd9:    c = 8'h2E;
      4'd10:   c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/gif_container_stream_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gif_container_stream_parser_unit
// GIF89a container parser: one file byte in, one event word out.
// ----------------------------------------------------------------------------
// Each accepted byte word yields exactly one result word. A byte waits in the
// input register, is decoded combinationally by the parser phase logic and
// lands in the result register; one word per cycle is sustained while the
// sink keeps out_ready_i high. The single parser state update per byte sets
// that rate. Write max_data_block on the cfg port only while no word is in
// flight; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module gif_container_stream_parser_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [7:0]     cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gcsp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gcsp_pkg::out_t      out_data_o
);

  logic           held_valid;
  gcsp_pkg::in_t  held_data;
  logic           out_full;
  logic           adv;
  gcsp_pkg::out_t res;

  // Advance when a word is held and the result slot is free or draining
  assign adv         = held_valid && (!out_full || out_ready_i);
  assign cfg_ready_o = 1'b1;

  gcsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (adv),
    .valid_o    (held_valid),
    .data_o     (held_data)
  );

  gcsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .item_i     (held_data),
    .res_o      (res)
  );

  gcsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .res_i       (res),
    .full_o      (out_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* hdl/gcsp_in_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcsp_in_reg
// Input register: holds one accepted word until the parser takes it.
// ----------------------------------------------------------------------------
module gcsp_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gcsp_pkg::in_t in_data_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output gcsp_pkg::in_t      data_o
);

  logic          valid_q, valid_d;
  gcsp_pkg::in_t data_q;

  // Accept when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* hdl/gcsp_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcsp_core
// Parser state and per-byte decode: one word in, one result word out.
// ----------------------------------------------------------------------------
module gcsp_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic          adv_i,
  input  wire gcsp_pkg::in_t item_i,
  output gcsp_pkg::out_t     res_o
);

  typedef enum logic [21:0] {
    PH_HDR       = 22'h000001,
    PH_LSD       = 22'h000002,
    PH_PAL       = 22'h000004,
    PH_BLOCK     = 22'h000008,
    PH_EXT_LABEL = 22'h000010,
    PH_GCE_SIZE  = 22'h000020,
    PH_GCE_BODY  = 22'h000040,
    PH_GCE_TERM  = 22'h000080,
    PH_APP_SIZE  = 22'h000100,
    PH_APP_BODY  = 22'h000200,
    PH_NS_SIZE   = 22'h000400,
    PH_NS_ID     = 22'h000800,
    PH_NS_LOOP   = 22'h001000,
    PH_NS_TERM   = 22'h002000,
    PH_SKIP_LEN  = 22'h004000,
    PH_SKIP_DATA = 22'h008000,
    PH_IMGDESC   = 22'h010000,
    PH_MINCODE   = 22'h020000,
    PH_DATA_LEN  = 22'h040000,
    PH_DATA_BYTE = 22'h080000,
    PH_DONE      = 22'h100000,
    PH_ERR       = 22'h200000
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        left_q, left_d;
  logic [63:0]       gath_q, gath_d;
  logic              nm_q, nm_d;
  logic              ploc_q, ploc_d;
  logic [8:0]        pleft_q, pleft_d;
  logic [1:0]        pmod_q, pmod_d;
  logic [7:0]        pidx_q, pidx_d;
  logic              anim_q, anim_d;
  gcsp_pkg::error_e  errc_q, errc_d;
  logic [7:0]        max_blk_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blk_q <= gcsp_pkg::MaxBlkReset;
    end else if (cfg_we_i) begin
      max_blk_q <= cfg_data_i;
    end
  end

  // Decode one byte
  always_comb begin
    phase_e           ph;
    logic [7:0]       b;
    logic [63:0]      g;
    logic [8:0]       pleft_n;
    logic [7:0]       left_n;
    logic             nm_n;
    gcsp_pkg::error_e err;
    gcsp_pkg::out_t   r;

    b = item_i.data_byte;
    // Start of file: restart from the reset state
    if (item_i.start_of_file) begin
      ph      = PH_HDR;
      cnt_d   = '0;
      left_d  = '0;
      gath_d  = '0;
      nm_d    = 1'b1;
      ploc_d  = 1'b0;
      pleft_d = '0;
      pmod_d  = '0;
      pidx_d  = '0;
      anim_d  = 1'b0;
    end else begin
      ph      = phase_q;
      cnt_d   = cnt_q;
      left_d  = left_q;
      gath_d  = gath_q;
      nm_d    = nm_q;
      ploc_d  = ploc_q;
      pleft_d = pleft_q;
      pmod_d  = pmod_q;
      pidx_d  = pidx_q;
      anim_d  = anim_q;
    end
    phase_d = ph;
    errc_d  = errc_q;
    err     = gcsp_pkg::ERR_NONE;
    g       = gath_d;
    pleft_n = pleft_d;
    left_n  = left_d;
    nm_n    = nm_d;
    r       = '0;

    case (ph)
      PH_HDR: begin
        if (cnt_d > 4'd5 || b != gcsp_pkg::sig_byte(cnt_d[2:0])) begin
          err = gcsp_pkg::ERR_HEADER;
        end else if (cnt_d == 4'd5) begin
          phase_d = PH_LSD;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          cnt_d = cnt_d + 4'd1;
        end
      end
      PH_LSD: begin
        if (!cnt_d[3]) gath_d[{cnt_d[2:0], 3'b000} +: 8] = b;
        g     = gath_d;
        cnt_d = cnt_d + 4'd1;
        if (cnt_d == 4'd7) begin
          r.event_res    = gcsp_pkg::EV_SCREEN;
          r.first_value  = g[15:0];
          r.second_value = g[31:16];
          cnt_d  = '0;
          gath_d = '0;
          nm_d   = 1'b1;
          if (g[39]) begin
            phase_d = PH_PAL;
            ploc_d  = 1'b0;
            pleft_d = 9'd2 << g[34:32];
            pmod_d  = '0;
            pidx_d  = '0;
          end else begin
            phase_d = PH_BLOCK;
          end
        end
      end
      PH_PAL: begin
        gath_d = {40'd0, gath_d[15:0], b};
        if (pmod_d == 2'd2) begin
          r.event_res   = ploc_d ? gcsp_pkg::EV_LOCAL : gcsp_pkg::EV_GLOBAL;
          r.first_value = {8'd0, pidx_d};
          r.palette_rgb = gath_d[23:0];
          if (pleft_d != 9'd0) pleft_n = pleft_d - 9'd1;
          pleft_d = pleft_n;
          if (pleft_n == 9'd0) begin
            phase_d = ploc_d ? PH_MINCODE : PH_BLOCK;
            cnt_d   = '0;
            gath_d  = '0;
            nm_d    = 1'b1;
          end else begin
            pmod_d = '0;
            pidx_d = pidx_d + 8'd1;
          end
        end else begin
          pmod_d = pmod_d + 2'd1;
        end
      end
      PH_BLOCK: begin
        cnt_d  = '0;
        gath_d = '0;
        nm_d   = 1'b1;
        if (b == gcsp_pkg::ExtIntro) begin
          phase_d = PH_EXT_LABEL;
        end else if (b == gcsp_pkg::ImgSep) begin
          phase_d = PH_IMGDESC;
        end else if (b == gcsp_pkg::Trailer) begin
          r.event_res = gcsp_pkg::EV_TRAILER;
          phase_d     = PH_DONE;
        end else begin
          err = gcsp_pkg::ERR_BLOCK_ID;
        end
      end
      PH_EXT_LABEL: begin
        cnt_d  = '0;
        gath_d = '0;
        nm_d   = 1'b1;
        if (b == gcsp_pkg::GctrlLabel) begin
          phase_d = PH_GCE_SIZE;
        end else if (b == gcsp_pkg::AppLabel) begin
          phase_d = PH_APP_SIZE;
        end else begin
          phase_d = PH_SKIP_LEN;
        end
      end
      PH_GCE_SIZE: begin
        if (b == gcsp_pkg::GctrlSize) begin
          phase_d = PH_GCE_BODY;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          err = gcsp_pkg::ERR_EXT_SIZE;
        end
      end
      PH_GCE_BODY: begin
        if (!cnt_d[3]) gath_d[{cnt_d[2:0], 3'b000} +: 8] = b;
        cnt_d = cnt_d + 4'd1;
        if (cnt_d == 4'd4) phase_d = PH_GCE_TERM;
      end
      PH_GCE_TERM: begin
        if (b != 8'd0) begin
          err = gcsp_pkg::ERR_TERMINATOR;
        end else begin
          r.event_res       = gcsp_pkg::EV_GCTRL;
          r.first_value     = g[23:8];
          r.second_value    = {8'd0, g[31:24]};
          r.transparency_on = g[0];
          r.disposal_method = g[4:2];
          phase_d = PH_BLOCK;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end
      end
      PH_APP_SIZE: begin
        if (b == gcsp_pkg::AppSize) begin
          phase_d = PH_APP_BODY;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          err = gcsp_pkg::ERR_EXT_SIZE;
        end
      end
      PH_APP_BODY: begin
        if (cnt_d > 4'd10 || b != gcsp_pkg::app_byte(cnt_d)) nm_n = 1'b0;
        if (cnt_d >= 4'd10) begin
          phase_d = nm_n ? PH_NS_SIZE : PH_SKIP_LEN;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          cnt_d = cnt_d + 4'd1;
          nm_d  = nm_n;
        end
      end
      PH_NS_SIZE: begin
        if (b == gcsp_pkg::LoopSubSize) begin
          phase_d = PH_NS_ID;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          err = gcsp_pkg::ERR_LOOP_BLOCK;
        end
      end
      PH_NS_ID: begin
        if (b == gcsp_pkg::LoopSubId) begin
          phase_d = PH_NS_LOOP;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          err = gcsp_pkg::ERR_LOOP_BLOCK;
        end
      end
      PH_NS_LOOP: begin
        if (!cnt_d[3]) gath_d[{cnt_d[2:0], 3'b000} +: 8] = b;
        cnt_d = cnt_d + 4'd1;
        if (cnt_d == 4'd2) phase_d = PH_NS_TERM;
      end
      PH_NS_TERM: begin
        if (b != 8'd0) begin
          err = gcsp_pkg::ERR_TERMINATOR;
        end else begin
          anim_d        = 1'b1;
          r.event_res   = gcsp_pkg::EV_LOOP;
          r.first_value = g[15:0];
          phase_d = PH_BLOCK;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end
      end
      PH_SKIP_LEN: begin
        if (b == 8'd0) begin
          phase_d = PH_BLOCK;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else begin
          left_d  = b;
          phase_d = PH_SKIP_DATA;
        end
      end
      PH_SKIP_DATA: begin
        if (left_d != 8'd0) left_n = left_d - 8'd1;
        left_d = left_n;
        if (left_n == 8'd0) phase_d = PH_SKIP_LEN;
      end
      PH_IMGDESC: begin
        if (!cnt_d[3]) gath_d[{cnt_d[2:0], 3'b000} +: 8] = b;
        g     = gath_d;
        cnt_d = cnt_d + 4'd1;
        if (cnt_d == 4'd9) begin
          r.event_res    = gcsp_pkg::EV_IMGDESC;
          r.first_value  = g[15:0];
          r.second_value = g[31:16];
          r.third_value  = g[47:32];
          r.fourth_value = g[63:48];
          r.interlaced   = b[6];
          cnt_d  = '0;
          gath_d = '0;
          nm_d   = 1'b1;
          if (b[7]) begin
            phase_d = PH_PAL;
            ploc_d  = 1'b1;
            pleft_d = 9'd2 << b[2:0];
            pmod_d  = '0;
            pidx_d  = '0;
          end else begin
            phase_d = PH_MINCODE;
          end
        end
      end
      PH_MINCODE: begin
        r.event_res   = gcsp_pkg::EV_MIN_CODE;
        r.first_value = {8'd0, b};
        phase_d = PH_DATA_LEN;
        cnt_d   = '0;
        gath_d  = '0;
        nm_d    = 1'b1;
      end
      PH_DATA_LEN: begin
        if (b == 8'd0) begin
          r.event_res = gcsp_pkg::EV_DATA_END;
          phase_d = PH_BLOCK;
          cnt_d   = '0;
          gath_d  = '0;
          nm_d    = 1'b1;
        end else if (b > max_blk_q) begin
          err = gcsp_pkg::ERR_DATA_LEN;
        end else begin
          left_d  = b;
          phase_d = PH_DATA_BYTE;
        end
      end
      PH_DATA_BYTE: begin
        r.event_res   = gcsp_pkg::EV_CODE_BYTE;
        r.first_value = {8'd0, b};
        if (left_d != 8'd0) left_n = left_d - 8'd1;
        left_d = left_n;
        if (left_n == 8'd0) phase_d = PH_DATA_LEN;
      end
      PH_ERR: begin
        err = errc_q;
      end
      default: begin
        // Trailer seen: stay quiet until the next file
      end
    endcase

    // Latch an error and blank the fields
    if (err != gcsp_pkg::ERR_NONE) begin
      phase_d      = PH_ERR;
      errc_d       = err;
      r            = '0;
      r.event_res  = gcsp_pkg::EV_ERROR;
      r.error_code = err;
    end
    r.animated = anim_d;
    res_o      = r;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      cnt_q   <= '0;
      left_q  <= '0;
      nm_q    <= 1'b1;
      ploc_q  <= 1'b0;
      pleft_q <= '0;
      pmod_q  <= '0;
      pidx_q  <= '0;
      anim_q  <= 1'b0;
      errc_q  <= gcsp_pkg::ERR_NONE;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      nm_q    <= nm_d;
      ploc_q  <= ploc_d;
      pleft_q <= pleft_d;
      pmod_q  <= pmod_d;
      pidx_q  <= pidx_d;
      anim_q  <= anim_d;
      errc_q  <= errc_d;
    end
  end

  // Gathered field bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gath_q <= '0;
    end else if (adv_i) begin
      gath_q <= gath_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/gcsp_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gcsp_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module gcsp_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire gcsp_pkg::out_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gcsp_pkg::out_t      out_data_o
);

  logic           valid_q, valid_d;
  gcsp_pkg::out_t data_q;

  // Fill on load, drain when taken
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign full_o      = valid_q;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

/* test/gif_stream_event_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gif_stream_event_checker
// Watches the parser's channels, predicts one event word per accepted byte
// word and compares it field by field with the result words that leave.
// ----------------------------------------------------------------------------
module gif_stream_event_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  gcsp_pkg::in_t    in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  gcsp_pkg::out_t   out_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);
  import gcsp_pkg::*;

  localparam logic [47:0] GifSig      = "GIF89a";
  localparam logic [87:0] LoopAppName = "NETSCAPE2.0";

  // Where the parser stands within the file
  typedef enum logic [4:0] {
    PH_HEADER, PH_SCREEN, PH_PALETTE, PH_BLOCK, PH_EXT_LABEL,
    PH_GCTRL_SIZE, PH_GCTRL_BODY, PH_GCTRL_TERM, PH_APP_SIZE, PH_APP_NAME,
    PH_LOOP_SIZE, PH_LOOP_ID, PH_LOOP_COUNT, PH_LOOP_TERM, PH_SKIP_LEN,
    PH_SKIP_DATA, PH_IMG_DESC, PH_MIN_CODE, PH_DATA_LEN, PH_DATA_BYTE,
    PH_DONE, PH_ERROR
  } phase_e;

  phase_e      phase;
  logic [9:0]  cnt;
  logic [7:0]  blk_left;
  logic [63:0] gath;
  logic        name_ok;
  logic        pal_local;
  logic [8:0]  pal_left;
  logic [15:0] loop_cnt;
  logic        anim;
  error_e      err_held;
  logic [7:0]  max_blk;

  out_t expected_events[$];
  out_t want;
  out_t fresh;
  logic field_bad;
  int   fail_count = 0;
  int   checked = 0;
  int   pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  task clear_state();
    phase     = PH_HEADER;
    cnt       = '0;
    blk_left  = '0;
    gath      = '0;
    name_ok   = 1'b1;
    pal_local = 1'b0;
    pal_left  = '0;
    loop_cnt  = '0;
    anim      = 1'b0;
    err_held  = ERR_NONE;
  endtask

  task enter_phase(input phase_e next);
    phase   = next;
    cnt     = '0;
    gath    = '0;
    name_ok = 1'b1;
  endtask

  // Gather the first eight bytes of a fixed-size field group, low byte first
  task store_byte(input logic [7:0] b);
    if (cnt < 10'd8) gath[8*cnt +: 8] = b;
  endtask

  task start_palette(input logic [7:0] flags, input logic is_local);
    enter_phase(PH_PALETTE);
    pal_local = is_local;
    pal_left  = 9'd2 << flags[2:0];
  endtask

  // Advance the parser by one byte word and build its event word
  task predict_event(input in_t word, output out_t r);
    logic [7:0]  b;
    logic [63:0] g;
    logic        last_entry;
    error_e      err;
    b = word.data_byte;
    err = ERR_NONE;
    r = '0;
    last_entry = 1'b0;
    if (word.start_of_file) clear_state();
    case (phase)
      PH_HEADER: begin
        if (cnt >= 10'd6 || b != GifSig[8*(5-cnt) +: 8]) begin
          err = ERR_HEADER;
        end else begin
          cnt = cnt + 1'b1;
          if (cnt == 10'd6) enter_phase(PH_SCREEN);
        end
      end
      PH_SCREEN: begin
        store_byte(b);
        cnt = cnt + 1'b1;
        if (cnt >= 10'd7) begin
          g = gath;
          r.event_res = EV_SCREEN;
          r.first_value = g[15:0];
          r.second_value = g[31:16];
          if (g[39]) start_palette(g[39:32], 1'b0);
          else enter_phase(PH_BLOCK);
        end
      end
      PH_PALETTE: begin
        gath = {40'd0, gath[15:0], b};
        if (cnt % 10'd3 == 10'd2) begin
          r.event_res = pal_local ? EV_LOCAL : EV_GLOBAL;
          r.first_value = 16'(cnt / 10'd3);
          r.palette_rgb = gath[23:0];
          if (pal_left != 0) pal_left = pal_left - 1'b1;
          if (pal_left == 0) begin
            enter_phase(pal_local ? PH_MIN_CODE : PH_BLOCK);
            last_entry = 1'b1;
          end
        end
        if (!last_entry) cnt = cnt + 1'b1;
      end
      PH_BLOCK: begin
        if (b == ExtIntro) begin
          enter_phase(PH_EXT_LABEL);
        end else if (b == ImgSep) begin
          enter_phase(PH_IMG_DESC);
        end else if (b == Trailer) begin
          r.event_res = EV_TRAILER;
          enter_phase(PH_DONE);
        end else begin
          err = ERR_BLOCK_ID;
        end
      end
      PH_EXT_LABEL: begin
        if (b == GctrlLabel) enter_phase(PH_GCTRL_SIZE);
        else if (b == AppLabel) enter_phase(PH_APP_SIZE);
        else enter_phase(PH_SKIP_LEN);
      end
      PH_GCTRL_SIZE: begin
        if (b == GctrlSize) enter_phase(PH_GCTRL_BODY);
        else err = ERR_EXT_SIZE;
      end
      PH_GCTRL_BODY: begin
        store_byte(b);
        cnt = cnt + 1'b1;
        if (cnt >= 10'd4) phase = PH_GCTRL_TERM;
      end
      PH_GCTRL_TERM: begin
        if (b != 8'h00) begin
          err = ERR_TERMINATOR;
        end else begin
          g = gath;
          r.event_res = EV_GCTRL;
          r.first_value = g[23:8];
          r.second_value = {8'd0, g[31:24]};
          r.transparency_on = g[0];
          r.disposal_method = g[4:2];
          enter_phase(PH_BLOCK);
        end
      end
      PH_APP_SIZE: begin
        if (b == AppSize) enter_phase(PH_APP_NAME);
        else err = ERR_EXT_SIZE;
      end
      PH_APP_NAME: begin
        if (cnt >= 10'd11 || b != LoopAppName[8*(10-cnt) +: 8]) name_ok = 1'b0;
        cnt = cnt + 1'b1;
        if (cnt >= 10'd11) enter_phase(name_ok ? PH_LOOP_SIZE : PH_SKIP_LEN);
      end
      PH_LOOP_SIZE: begin
        if (b == LoopSubSize) enter_phase(PH_LOOP_ID);
        else err = ERR_LOOP_BLOCK;
      end
      PH_LOOP_ID: begin
        if (b == LoopSubId) enter_phase(PH_LOOP_COUNT);
        else err = ERR_LOOP_BLOCK;
      end
      PH_LOOP_COUNT: begin
        store_byte(b);
        cnt = cnt + 1'b1;
        if (cnt >= 10'd2) phase = PH_LOOP_TERM;
      end
      PH_LOOP_TERM: begin
        if (b != 8'h00) begin
          err = ERR_TERMINATOR;
        end else begin
          loop_cnt = gath[15:0];
          anim = 1'b1;
          r.event_res = EV_LOOP;
          r.first_value = loop_cnt;
          enter_phase(PH_BLOCK);
        end
      end
      PH_SKIP_LEN: begin
        if (b == 8'h00) begin
          enter_phase(PH_BLOCK);
        end else begin
          blk_left = b;
          phase = PH_SKIP_DATA;
        end
      end
      PH_SKIP_DATA: begin
        if (blk_left != 0) blk_left = blk_left - 1'b1;
        if (blk_left == 0) phase = PH_SKIP_LEN;
      end
      PH_IMG_DESC: begin
        store_byte(b);
        cnt = cnt + 1'b1;
        if (cnt >= 10'd9) begin
          g = gath;
          r.event_res = EV_IMGDESC;
          r.first_value = g[15:0];
          r.second_value = g[31:16];
          r.third_value = g[47:32];
          r.fourth_value = g[63:48];
          r.interlaced = b[6];
          if (b[7]) start_palette(b, 1'b1);
          else enter_phase(PH_MIN_CODE);
        end
      end
      PH_MIN_CODE: begin
        r.event_res = EV_MIN_CODE;
        r.first_value = {8'd0, b};
        enter_phase(PH_DATA_LEN);
      end
      PH_DATA_LEN: begin
        if (b == 8'h00) begin
          r.event_res = EV_DATA_END;
          enter_phase(PH_BLOCK);
        end else if (b > max_blk) begin
          err = ERR_DATA_LEN;
        end else begin
          blk_left = b;
          phase = PH_DATA_BYTE;
        end
      end
      PH_DATA_BYTE: begin
        r.event_res = EV_CODE_BYTE;
        r.first_value = {8'd0, b};
        if (blk_left != 0) blk_left = blk_left - 1'b1;
        if (blk_left == 0) phase = PH_DATA_LEN;
      end
      PH_ERROR: err = err_held;
      default: ;
    endcase
    // Latch an error and clear the payload fields; the animated flag still follows
    if (err != ERR_NONE) begin
      phase = PH_ERROR;
      err_held = err;
      r = '0;
      r.event_res = EV_ERROR;
      r.error_code = err;
    end
    r.animated = anim;
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_val,
                             input logic [23:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
               $time, name, exp_val, got_val);
      field_bad = 1'b1;
    end
  endtask

  // Compare leaving words first: a word accepted at this edge is always newer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blk = MaxBlkReset;
      clear_state();
      expected_events.delete();
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result word 0x%0h with no prediction waiting",
                   $time, out_data_i);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          field_bad = 1'b0;
          check_field("event_res", 24'(want.event_res),
                      24'(out_data_i.event_res));
          check_field("first_value", 24'(want.first_value),
                      24'(out_data_i.first_value));
          check_field("second_value", 24'(want.second_value),
                      24'(out_data_i.second_value));
          check_field("third_value", 24'(want.third_value),
                      24'(out_data_i.third_value));
          check_field("fourth_value", 24'(want.fourth_value),
                      24'(out_data_i.fourth_value));
          check_field("palette_rgb", want.palette_rgb, out_data_i.palette_rgb);
          check_field("transparency_on", 24'(want.transparency_on),
                      24'(out_data_i.transparency_on));
          check_field("disposal_method", 24'(want.disposal_method),
                      24'(out_data_i.disposal_method));
          check_field("interlaced", 24'(want.interlaced),
                      24'(out_data_i.interlaced));
          check_field("animated", 24'(want.animated),
                      24'(out_data_i.animated));
          check_field("error_code", 24'(want.error_code),
                      24'(out_data_i.error_code));
          if (field_bad) fail_count++;
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) max_blk = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        predict_event(in_data_i, fresh);
        expected_events.push_back(fresh);
      end
      pending = expected_events.size();
    end
  end

endmodule

/* test/gif_container_stream_parser_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gif_container_stream_parser_unit_tb
// Feeds GIF files byte by byte through the parser under random idling on
// both sides and several max_data_block settings; the event checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module gif_container_stream_parser_unit_tb;
  import gcsp_pkg::*;

  localparam int ItemTarget  = 1950;
  localparam int NumSettings = 6;
  localparam int IdleLimit   = 2000;

  localparam logic [47:0] GifSig      = "GIF89a";
  localparam logic [87:0] LoopAppName = "NETSCAPE2.0";

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  in_t        in_word;
  logic       out_valid;
  logic       out_ready;
  out_t       out_word;

  int fail_count;
  int pending;
  int checked;

  logic [7:0] file_q[$];
  logic [7:0] max_blk_now = MaxBlkReset;
  logic [7:0] next_max;
  int         idle_rates[4] = '{0, 5, 15, 35};
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  int         settings_done = 0;
  int         idle_cycles = 0;

  gif_container_stream_parser_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  gif_stream_event_checker u_event_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // End the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // Favor the extremes of 16-bit fields
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small palettes, now and then the full 256 entries
  function automatic logic [2:0] pick_table_size();
    return ($urandom_range(0, 79) == 0) ? 3'd7 : 3'($urandom_range(0, 2));
  endfunction

  task automatic push_byte(input logic [7:0] v);
    file_q.push_back(v);
  endtask

  task automatic push_word16(input logic [15:0] v);
    push_byte(v[7:0]);
    push_byte(v[15:8]);
  endtask

  task automatic push_palette(input logic [2:0] sz);
    repeat (3 * (2 << sz)) push_byte(8'($urandom));
  endtask

  task automatic push_subblocks(input int max_len, input int count);
    int len;
    repeat (count) begin
      len = $urandom_range(1, max_len);
      push_byte(8'(len));
      repeat (len) push_byte(8'($urandom));
    end
    push_byte(8'h00);
  endtask

  // Build one file: mostly well formed, with the odd broken field or noise
  task automatic build_random_file();
    int         bad_at;
    int         fault;
    int         which;
    int         len;
    int         cap;
    logic [7:0] v;
    logic [7:0] flags;
    file_q.delete();
    if ($urandom_range(0, 29) == 0) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
      return;
    end
    // Signature, now and then with one wrong byte
    bad_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 5) : -1;
    for (int i = 0; i < 6; i++) begin
      v = GifSig[8*(5-i) +: 8];
      if (i == bad_at) v = v ^ nonzero_byte();
      push_byte(v);
    end
    // Screen descriptor and optional global palette
    push_word16(pick16());
    push_word16(pick16());
    flags = 8'($urandom);
    flags[7] = 1'($urandom_range(0, 1));
    flags[2:0] = pick_table_size();
    push_byte(flags);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    if (flags[7]) push_palette(flags[2:0]);
    repeat ($urandom_range(1, 6)) begin
      fault = $urandom_range(0, 39);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          // graphic control
          push_byte(ExtIntro);
          push_byte(GctrlLabel);
          push_byte(fault == 0 ? GctrlSize ^ nonzero_byte() : GctrlSize);
          repeat (4) push_byte(8'($urandom));
          push_byte(fault == 1 ? nonzero_byte() : 8'h00);
        end
        4, 5: begin
          // loop block
          push_byte(ExtIntro);
          push_byte(AppLabel);
          push_byte(fault == 0 ? AppSize ^ nonzero_byte() : AppSize);
          for (int i = 0; i < 11; i++) push_byte(LoopAppName[8*(10-i) +: 8]);
          push_byte(fault == 1 ? LoopSubSize ^ nonzero_byte() : LoopSubSize);
          push_byte(fault == 2 ? LoopSubId ^ nonzero_byte() : LoopSubId);
          push_word16(pick16());
          push_byte(fault == 3 ? nonzero_byte() : 8'h00);
        end
        6: begin
          // other application: near-miss or random identifier, then skip
          push_byte(ExtIntro);
          push_byte(AppLabel);
          push_byte(AppSize);
          which = $urandom_range(0, 11);
          for (int i = 0; i < 11; i++) begin
            v = LoopAppName[8*(10-i) +: 8];
            if (which == 11) v = 8'($urandom);
            else if (i == which) v = v ^ nonzero_byte();
            push_byte(v);
          end
          push_subblocks(16, $urandom_range(0, 3));
        end
        7, 8: begin
          // other extension label, skipped by its sub-blocks
          do v = 8'($urandom); while (v == GctrlLabel || v == AppLabel);
          push_byte(ExtIntro);
          push_byte(v);
          push_subblocks(24, $urandom_range(0, 3));
        end
        19: begin
          do v = 8'($urandom); while (v == ExtIntro || v == ImgSep || v == Trailer);
          push_byte(v);
        end
        default: begin
          // image: descriptor, optional local palette, code size, data
          push_byte(ImgSep);
          repeat (4) push_word16(pick16());
          flags = 8'($urandom);
          flags[7] = ($urandom_range(0, 4) < 2);
          flags[2:0] = pick_table_size();
          push_byte(flags);
          if (flags[7]) push_palette(flags[2:0]);
          push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) :
                    8'($urandom_range(2, 8)));
          cap = (max_blk_now < 20) ? int'(max_blk_now) : 20;
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 11))
              0:       len = $urandom_range(1, 255);
              1:       len = (max_blk_now <= 40) ? int'(max_blk_now) : cap;
              2:       len = (max_blk_now < 255) ? int'(max_blk_now) + 1 : cap;
              default: len = $urandom_range(1, cap);
            endcase
            push_byte(8'(len));
            // a too long length ends parsing, so keep its tail short
            repeat ((len > max_blk_now) ? 2 : len) push_byte(8'($urandom));
          end
          push_byte(8'h00);
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_byte(Trailer);
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
  endtask

  // Send the file one byte word at a time; its first word usually restarts the parser
  task automatic send_file();
    logic sof;
    for (int i = 0; i < file_q.size(); i++) begin
      sof = (i == 0) ? (files_sent < 2 || $urandom_range(0, 19) != 0) :
                       ($urandom_range(0, 399) == 0);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_word <= '{data_byte: file_q[i], start_of_file: sof};
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    files_sent++;
  endtask

  // Drain the parser, then write the register
  task automatic write_max_block(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    max_blk_now = v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int s = 0; s < NumSettings; s++) begin
      case (s)
        0:       next_max = MaxBlkReset;
        1:       next_max = 8'd1;
        3:       next_max = 8'd8;
        5:       next_max = MaxBlkReset;
        default: next_max = 8'($urandom_range(2, 254));
      endcase
      write_max_block(next_max);
      settings_done++;
      // hold both sides steady through the last setting
      send_idle_pct = (s == NumSettings - 1) ? 0 : idle_rates[$urandom_range(1, 3)];
      recv_idle_pct = (s == NumSettings - 1) ? 0 : idle_rates[$urandom_range(1, 3)];
      if (s == 0) begin
        // wrong third signature byte, then the latched error
        file_q = '{8'h47, 8'h49, 8'h58, 8'h00};
        send_file();
        // widest canvas, no palette, trailer, then a byte that is ignored
        file_q = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'hFF, 8'hFF,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, Trailer, 8'h00};
        send_file();
      end
      while (bytes_sent < ItemTarget * (s + 1) / NumSettings) begin
        build_random_file();
        send_file();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d byte words in %0d files over %0d max_data_block settings",
             bytes_sent, files_sent, settings_done);
    $display("Compared %0d event words with %0d failing", checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
